>>> rtl/pib_pkg.sv
// ----------------------------------------------------------------------------
// pib_pkg
// Shared types, constants and helpers for the palette index builder.
// ----------------------------------------------------------------------------
package pib_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int POSITION_BITS = 16;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CLIP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = CFG_IDX_W'(1);

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SKIP  = 2'd3;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

  typedef struct packed {
    logic [31:0]              pixel_word;
    logic [POSITION_BITS-1:0] position;
    logic                     start_chunk;
  } pib_pixel_t;

  typedef struct packed {
    logic [7:0]               palette_index;
    logic [POSITION_BITS-1:0] position_out;
    logic [1:0]               status;
    logic [31:0]              new_color;
  } pib_result_t;

  typedef struct packed {
    logic       load;
    logic       scan_clear;
    logic       scan_issue;
    logic       set_result;
    logic [1:0] res_status;
    logic       emit;
  } pib_cmd_t;

  typedef struct packed {
    logic failed;
    logic hit;
    logic more;
    logic full;
    logic out_busy;
  } pib_stat_t;

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/pib_datapath.sv
// ----------------------------------------------------------------------------
// pib_datapath
// Color buffer, palette memory, scan pointer, result and output registers.
// ----------------------------------------------------------------------------
module pib_datapath import pib_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  pib_cmd_t              cmd,
  output pib_stat_t             stat,
  input  pib_pixel_t            pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output pib_result_t           result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [8:0]        alpha_clip;
  logic [2:0]               pixel_bytes;
  logic [31:0]              color_buffer;
  logic                     chunk_failed;
  logic [CNT_W-1:0]         palette_count;
  logic [CNT_W-1:0]         scan_addr;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_valid;
  logic [31:0]              rd_data;
  logic [POSITION_BITS-1:0] position;
  pib_result_t              res;
  logic [31:0]              palette_store [PALETTE_DEPTH];

  logic [31:0] base;
  logic        fail_eff;
  logic [31:0] mask;
  logic [31:0] merged;
  logic [31:0] color_next;
  logic        mem_write;

  always_comb begin
    base       = pixel.start_chunk ? OPAQUE_BLACK : color_buffer;
    fail_eff   = pixel.start_chunk ? 1'b0 : chunk_failed;
    mask       = byte_mask(pixel_bytes);
    merged     = (base & ~mask) | (pixel.pixel_word & mask);
    color_next = merged;
    if (fail_eff) begin
      color_next = base;
    end else if ($signed({1'b0, merged[31:24]}) <= alpha_clip) begin
      color_next = 32'h0;
    end
  end

  assign mem_write = cmd.set_result && (cmd.res_status == ST_ADDED);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_clip    <= -9'sd1;
      pixel_bytes   <= 3'd4;
      color_buffer  <= OPAQUE_BLACK;
      chunk_failed  <= 1'b0;
      palette_count <= '0;
      scan_addr     <= '0;
      rd_valid      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ALPHA_CLIP) alpha_clip <= $signed(cfg_data);
        if (cfg_index == REG_PIXEL_BYTES) pixel_bytes <= cfg_data[2:0];
      end
      if (cmd.load) begin
        color_buffer <= color_next;
        chunk_failed <= fail_eff;
      end
      if (cmd.scan_clear) begin
        scan_addr <= '0;
      end else if (cmd.scan_issue) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
      rd_valid <= cmd.scan_issue;
      if (mem_write) palette_count <= palette_count + CNT_W'(1);
      if (cmd.set_result && (cmd.res_status == ST_FULL)) chunk_failed <= 1'b1;
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_write) palette_store[palette_count[IDX_W-1:0]] <= color_buffer;
    if (cmd.scan_issue) rd_data <= palette_store[scan_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) position <= pixel.position;
    if (cmd.scan_issue) rd_idx <= scan_addr[IDX_W-1:0];
    if (cmd.set_result) begin
      res.position_out <= position;
      res.status       <= cmd.res_status;
      case (cmd.res_status)
        ST_FOUND: begin
          res.palette_index <= 8'(rd_idx);
          res.new_color     <= 32'h0;
        end
        ST_ADDED: begin
          res.palette_index <= 8'(palette_count[IDX_W-1:0]);
          res.new_color     <= color_buffer;
        end
        default: begin
          res.palette_index <= 8'h0;
          res.new_color     <= 32'h0;
        end
      endcase
    end
    if (cmd.emit) result <= res;
  end

  assign stat.failed   = chunk_failed;
  assign stat.hit      = rd_valid && (rd_data == color_buffer);
  assign stat.more     = scan_addr < palette_count;
  assign stat.full     = palette_count == CNT_W'(PALETTE_DEPTH);
  assign stat.out_busy = result_valid && result_stall;

endmodule

>>> rtl/pib_ctrl.sv
// ----------------------------------------------------------------------------
// pib_ctrl
// Sequencer: accepts a pixel, walks the palette, settles the result.
// ----------------------------------------------------------------------------
module pib_ctrl import pib_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pixel_valid,
  output logic      pixel_stall,
  input  pib_stat_t stat,
  output pib_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign pixel_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.failed) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ST_SKIP;
          state_next     = S_FINISH;
        end else if (stat.hit) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ST_FOUND;
          state_next     = S_FINISH;
        end else if (stat.more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          cmd.set_result = 1'b1;
          cmd.res_status = stat.full ? ST_FULL : ST_ADDED;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/palette_index_builder_top.sv
// ----------------------------------------------------------------------------
// palette_index_builder_top
// Maps pixels to 8-bit palette indexes, appending new colors as they appear.
// ----------------------------------------------------------------------------
// One pixel is in work at a time. A pixel with no matching entry is compared
// with every palette entry stored so far before it is added, or marked full
// when the palette holds 256 entries; a match ends the search early, and a
// pixel skipped after a chunk failure is not searched. The search reads the
// palette memory one entry per cycle through its single read port. The
// result register lets the next pixel be accepted while a result still
// waits. The palette memory needs no clearing after reset: only entries
// already written are searched.
// ----------------------------------------------------------------------------
module palette_index_builder_top import pib_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pib_pixel_t            pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output pib_result_t           result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pib_cmd_t  cmd;
  pib_stat_t stat;

  assign cfg_ready = 1'b1;

  pib_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  pib_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

>>> rtl/pib_checker.sv
// ----------------------------------------------------------------------------
// pib_checker
// Port-level checks for the palette index builder, bound to the top level.
// ----------------------------------------------------------------------------
module pib_checker import pib_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  pixel_valid,
  input logic                  pixel_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input pib_result_t           result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall && !rst |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !rst |=> pixel_stall)
    else $error("second item accepted while one is in work");

  a_found_no_color: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FOUND) |-> result.new_color == 32'h0)
    else $error("found result carries a new color");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FULL || result.status == ST_SKIP)
      |-> result.palette_index == 8'h0 && result.new_color == 32'h0)
    else $error("failed or skipped result not zeroed");

endmodule

bind palette_index_builder_top pib_checker u_pib_checker (.*);
